// File: rtl/tfr_pkg.sv
// Shared constants, types and the character-to-tile map of the text renderer.
`default_nettype none

package tfr_pkg;

  localparam int unsigned TILE_SIZE_DEF = 8;
  localparam int unsigned NUM_TILES_DEF = 64;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned OUT_USER_W = 3;

  localparam logic [CFG_W-1:0] TPR_RESET    = 7'd26;
  localparam logic [CFG_W-1:0] TCOUNT_RESET = 7'd64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TILES_PER_ROW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_COUNT    = 2'd1;

  // Item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNMAPPED = 2'd1;
  localparam logic [1:0] ST_BEYOND   = 2'd2;
  localparam logic [1:0] ST_SKIPPED  = 2'd3;

  // Character codes
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_QUERY   = 8'h3F;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic [7:0] PUNCT_OFS = 8'd10;

  typedef struct packed {
    logic       hit;
    logic [7:0] tile;
  } char_map_t;

  function automatic char_map_t map_char(input logic [7:0] ch, input logic [CFG_W-1:0] base);
    char_map_t  m;
    logic [7:0] base8;
    base8  = {1'b0, base};
    m.hit  = 1'b1;
    m.tile = '0;
    if (ch inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
      m.tile = ch - CH_UPPER_A;
    end else if (ch inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
      m.tile = ch - CH_LOWER_A;
    end else if (ch inside {[CH_ZERO:CH_NINE]}) begin
      m.tile = base8 + (ch - CH_ZERO);
    end else begin
      case (ch)
        CH_DOT:   m.tile = base8 + PUNCT_OFS;
        CH_COLON: m.tile = base8 + PUNCT_OFS + 8'd1;
        CH_BANG:  m.tile = base8 + PUNCT_OFS + 8'd2;
        CH_QUERY: m.tile = base8 + PUNCT_OFS + 8'd3;
        CH_PLUS:  m.tile = base8 + PUNCT_OFS + 8'd4;
        CH_MINUS: m.tile = base8 + PUNCT_OFS + 8'd5;
        CH_SLASH: m.tile = base8 + PUNCT_OFS + 8'd6;
        CH_SPACE: m.tile = base8 + PUNCT_OFS + 8'd7;
        default:  m.hit  = 1'b0;
      endcase
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tfr_store.sv
// Tile store: single write port, single registered read port.
`default_nettype none

module tfr_store #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [7:0]        wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output      logic [7:0]        rd_data_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_data_q;

  // Read data holds while rd_en_i is low
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/tfr_ctrl.sv
// Item sequencer: char mapping, tile scan over the store, result register.
`default_nettype none

module tfr_ctrl #(
  parameter int unsigned TILE_SIZE = 8,
  parameter int unsigned NUM_TILES = 64,
  parameter int unsigned ADDR_W    = 12
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [tfr_pkg::CFG_W-1:0]         tiles_per_row_i,
  input  wire logic [tfr_pkg::CFG_W-1:0]         tile_count_i,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  input  wire logic [tfr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  wire logic [tfr_pkg::IN_USER_W-1:0]     s_axis_tuser,
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output      logic [tfr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output      logic [tfr_pkg::OUT_USER_W-1:0]    m_axis_tuser,
  output      logic                              m_axis_tlast,
  output      logic                              wr_en_o,
  output      logic [ADDR_W-1:0]                 wr_addr_o,
  output      logic [7:0]                        wr_data_o,
  output      logic                              rd_en_o,
  output      logic [ADDR_W-1:0]                 rd_addr_o,
  input  wire logic [7:0]                        rd_data_i
);
  import tfr_pkg::*;

  localparam int unsigned TILE_PIXELS = TILE_SIZE * TILE_SIZE;
  localparam int unsigned IDX_W       = $clog2(TILE_SIZE);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_READ   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;
  localparam logic [1:0] S_STATUS = 2'd3;

  // Input fields
  logic               in_mode;
  logic               in_first;
  logic [5:0]         in_tile;
  logic [5:0]         in_poff;
  logic [7:0]         in_pval;
  logic [7:0]         in_char;
  logic [COORD_W-1:0] in_sx;
  logic [COORD_W-1:0] in_sy;

  assign in_mode  = s_axis_tuser[0];
  assign in_first = s_axis_tuser[1];
  assign in_tile  = s_axis_tdata[5:0];
  assign in_poff  = s_axis_tdata[11:6];
  assign in_pval  = s_axis_tdata[19:12];
  assign in_char  = s_axis_tdata[27:20];
  assign in_sx    = s_axis_tdata[39:28];
  assign in_sy    = s_axis_tdata[51:40];

  logic [1:0]         state_q, state_d;
  logic [COORD_W-1:0] cursor_q, cursor_d;
  logic               abort_q, abort_d;
  logic [COORD_W-1:0] sy_q, sy_d;
  logic [1:0]         status_q, status_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [IDX_W-1:0]   col_q, col_d, row_q, row_d;
  logic               iss_done_q, iss_done_d;
  logic               rd_valid_q, rd_valid_d;
  logic [IDX_W-1:0]   rd_col_q, rd_col_d, rd_row_q, rd_row_d;
  logic               pend_valid_q, pend_valid_d;
  logic [COORD_W-1:0] pend_x_q, pend_x_d, pend_y_q, pend_y_d;
  logic [7:0]         pend_c_q, pend_c_d;

  logic               out_valid_q, out_valid_d;
  logic [COORD_W-1:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic [7:0]         out_c_q, out_c_d;
  logic               out_wr_q, out_wr_d;
  logic [1:0]         out_st_q, out_st_d;
  logic               out_last_q, out_last_d;
  logic               out_load;

  logic               accept, out_free, consume, issue;
  char_map_t          cmap;
  logic               beyond;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign consume       = rd_valid_q && ((rd_data_i == 8'd0) || !pend_valid_q || out_free);
  assign issue         = (state_q == S_READ) && !iss_done_q && (!rd_valid_q || consume);

  assign cmap   = map_char(in_char, tiles_per_row_i);
  assign beyond = (9'(cmap.tile) >= 9'(tile_count_i)) || (9'(cmap.tile) >= 9'(NUM_TILES));

  // Load path writes straight into the store
  assign wr_en_o   = accept && (in_mode == MODE_LOAD) && (9'(in_tile) < 9'(NUM_TILES))
                     && (7'(in_poff) < 7'(TILE_PIXELS));
  assign wr_addr_o = ADDR_W'(in_tile) * ADDR_W'(TILE_PIXELS) + ADDR_W'(in_poff);
  assign wr_data_o = in_pval;
  assign rd_en_o   = issue;
  assign rd_addr_o = addr_q;

  always_comb begin
    state_d      = state_q;
    cursor_d     = cursor_q;
    abort_d      = abort_q;
    sy_d         = sy_q;
    status_d     = status_q;
    addr_d       = addr_q;
    col_d        = col_q;
    row_d        = row_q;
    iss_done_d   = iss_done_q;
    rd_valid_d   = rd_valid_q;
    rd_col_d     = rd_col_q;
    rd_row_d     = rd_row_q;
    pend_valid_d = pend_valid_q;
    pend_x_d     = pend_x_q;
    pend_y_d     = pend_y_q;
    pend_c_d     = pend_c_q;
    out_load     = 1'b0;
    out_x_d      = '0;
    out_y_d      = '0;
    out_c_d      = '0;
    out_wr_d     = 1'b0;
    out_st_d     = ST_OK;
    out_last_d   = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (accept && (in_mode == MODE_DRAW)) begin
          if (in_first) begin
            cursor_d = in_sx;
            abort_d  = 1'b0;
          end
          if (!in_first && abort_q) begin
            status_d = ST_SKIPPED;
            state_d  = S_STATUS;
          end else if (!cmap.hit) begin
            abort_d  = 1'b1;
            status_d = ST_UNMAPPED;
            state_d  = S_STATUS;
          end else if (beyond) begin
            abort_d  = 1'b1;
            status_d = ST_BEYOND;
            state_d  = S_STATUS;
          end else begin
            addr_d     = ADDR_W'(cmap.tile) * ADDR_W'(TILE_PIXELS);
            col_d      = '0;
            row_d      = '0;
            iss_done_d = 1'b0;
            sy_d       = in_sy;
            state_d    = S_READ;
          end
        end
      end
      S_READ: begin
        if (issue) begin
          addr_d   = addr_q + ADDR_W'(1);
          rd_col_d = col_q;
          rd_row_d = row_q;
          if (col_q == IDX_W'(TILE_SIZE - 1)) begin
            col_d = '0;
            if (row_q == IDX_W'(TILE_SIZE - 1)) begin
              iss_done_d = 1'b1;
            end else begin
              row_d = row_q + IDX_W'(1);
            end
          end else begin
            col_d = col_q + IDX_W'(1);
          end
        end
        if (issue) begin
          rd_valid_d = 1'b1;
        end else if (consume) begin
          rd_valid_d = 1'b0;
        end
        // Hold back one lit pixel so the final one can carry last
        if (consume && (rd_data_i != 8'd0)) begin
          if (pend_valid_q) begin
            out_load   = 1'b1;
            out_x_d    = pend_x_q;
            out_y_d    = pend_y_q;
            out_c_d    = pend_c_q;
            out_wr_d   = 1'b1;
            out_last_d = 1'b0;
          end
          pend_valid_d = 1'b1;
          pend_x_d     = cursor_q + COORD_W'(rd_col_q);
          pend_y_d     = sy_q + COORD_W'(rd_row_q);
          pend_c_d     = rd_data_i;
        end
        if (iss_done_q && !rd_valid_q) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          if (pend_valid_q) begin
            out_x_d  = pend_x_q;
            out_y_d  = pend_y_q;
            out_c_d  = pend_c_q;
            out_wr_d = 1'b1;
          end
          pend_valid_d = 1'b0;
          cursor_d     = cursor_q + COORD_W'(TILE_SIZE);
          state_d      = S_IDLE;
        end
      end
      S_STATUS: begin
        if (out_free) begin
          out_load = 1'b1;
          out_st_d = status_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cursor_q     <= '0;
      abort_q      <= 1'b0;
      iss_done_q   <= 1'b1;
      rd_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cursor_q     <= cursor_d;
      abort_q      <= abort_d;
      iss_done_q   <= iss_done_d;
      rd_valid_q   <= rd_valid_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sy_q     <= sy_d;
    status_q <= status_d;
    addr_q   <= addr_d;
    col_q    <= col_d;
    row_q    <= row_d;
    rd_col_q <= rd_col_d;
    rd_row_q <= rd_row_d;
    pend_x_q <= pend_x_d;
    pend_y_q <= pend_y_d;
    pend_c_q <= pend_c_d;
    if (out_load) begin
      out_x_q    <= out_x_d;
      out_y_q    <= out_y_d;
      out_c_q    <= out_c_d;
      out_wr_q   <= out_wr_d;
      out_st_q   <= out_st_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_c_q, out_y_q, out_x_q};
  assign m_axis_tuser  = {out_st_q, out_wr_q};
  assign m_axis_tlast  = out_last_q;

  a_no_read_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !rd_valid_q)
    else $error("store read outstanding while idle");

  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> ((state_q == S_READ) || (state_q == S_FINISH)))
    else $error("held pixel outside a tile scan");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en_o && wr_en_o))
    else $error("store read and load write in the same cycle");

  a_finish_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FINISH) && out_free) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("character end did not present a final beat");

endmodule

`default_nettype wire

// File: rtl/tile_font_text_renderer_unit.sv
// A load beat is written in the cycle it is accepted and gives no result.
// A draw beat that fails or is skipped gives its single result via state S_STATUS.
// A drawn character reads TILE_SIZE*TILE_SIZE pixels, one store read per cycle unless the
// output stalls, through the tile store's single read port; one item is in work at a time.
// Reset (rst_ni low, asynchronous) clears cursor, abort flag, sequencer and output valid,
// and sets the registers to 26 and 64; the tile store is not cleared.
`default_nettype none

module tile_font_text_renderer_unit
  import tfr_pkg::*;
#(
  parameter int unsigned TILE_SIZE = TILE_SIZE_DEF,
  parameter int unsigned NUM_TILES = NUM_TILES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // tdata: tile_number[5:0], pixel_offset[11:6], pixel_value[19:12], char_code[27:20],
  //        start_x[39:28], start_y[51:40], zero pad[55:52]
  // tuser: mode[0], first_of_string[1]; tlast: last_of_string
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  input  wire logic [tfr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  wire logic [tfr_pkg::IN_USER_W-1:0]   s_axis_tuser,
  input  wire logic                            s_axis_tlast,
  // tdata: pixel_x[11:0], pixel_y[23:12], color[31:24]
  // tuser: write_pixel[0], status[2:1]; tlast: last
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output      logic [tfr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output      logic [tfr_pkg::OUT_USER_W-1:0]  m_axis_tuser,
  output      logic                            m_axis_tlast,
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [tfr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [tfr_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int unsigned DEPTH  = NUM_TILES * TILE_SIZE * TILE_SIZE;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic [CFG_W-1:0]  tpr_q, tpr_d;
  logic [CFG_W-1:0]  tcount_q, tcount_d;
  logic              cfg_we;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [7:0]        wr_data, rd_data;

  // String end marker carries no state here; results mark their own end
  logic              unused_tlast;
  assign unused_tlast = s_axis_tlast;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    tpr_d    = tpr_q;
    tcount_d = tcount_q;
    if (cfg_we) begin
      case (cfg_index_i)
        REG_TILES_PER_ROW: tpr_d    = cfg_data_i;
        REG_TILE_COUNT:    tcount_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpr_q    <= TPR_RESET;
      tcount_q <= TCOUNT_RESET;
    end else begin
      tpr_q    <= tpr_d;
      tcount_q <= tcount_d;
    end
  end

  tfr_ctrl #(
    .TILE_SIZE (TILE_SIZE),
    .NUM_TILES (NUM_TILES),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tiles_per_row_i (tpr_q),
    .tile_count_i    (tcount_q),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .m_axis_tlast    (m_axis_tlast),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data)
  );

  tfr_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

endmodule

`default_nettype wire

// File: test/tile_font_text_renderer_unit_tb.sv
// Self-checking testbench for the tile font text renderer: tile loads, character draws, register settings.
`timescale 1ns / 1ps

module testbench;
  import tfr_pkg::*;

  localparam int TILE_PIX    = TILE_SIZE_DEF * TILE_SIZE_DEF;
  localparam int DRAIN_WAIT  = 2 * TILE_PIX + 20;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic        mode;
    logic [5:0]  tile_num;
    logic [5:0]  pix_ofs;
    logic [7:0]  pix_val;
    logic [7:0]  ch;
    logic [11:0] sx;
    logic [11:0] sy;
    logic        first;
    logic        last_ch;
  } text_item_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  color;
    logic        wr;
    logic [1:0]  status;
    logic        last;
  } pixel_write_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_W-1:0]      cfg_data_i = '0;

  // Shadow state of the renderer
  logic [7:0]   glyph_store [0:NUM_TILES_DEF*TILE_PIX-1];
  logic [11:0]  cursor_col = '0;
  logic         string_dead = 1'b0;
  logic [6:0]   digit_base = TPR_RESET;
  logic [6:0]   tile_limit = TCOUNT_RESET;

  pixel_write_t pending_writes [$];
  int           mismatch_count = 0;
  int           idle_pct = 0;
  int           stall_pct = 0;
  int           cycle_count = 0;

  tile_font_text_renderer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : result_check
    pixel_write_t want;
    pixel_write_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{x: m_axis_tdata[11:0], y: m_axis_tdata[23:12], color: m_axis_tdata[31:24],
              wr: m_axis_tuser[0], status: m_axis_tuser[2:1], last: m_axis_tlast};
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected beat x=%0d y=%0d c=%0d wr=%0b st=%0d last=%0b",
                                  got.x, got.y, got.color, got.wr, got.status, got.last));
      end else begin
        want = pending_writes.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf(
            "got x=%0d y=%0d c=%0d wr=%0b st=%0d last=%0b, want x=%0d y=%0d c=%0d wr=%0b st=%0d last=%0b",
            got.x, got.y, got.color, got.wr, got.status, got.last,
            want.x, want.y, want.color, want.wr, want.status, want.last));
        end
      end
    end
  end

  // Tile index of a character, or -1 where it has no glyph
  function automatic int glyph_index(input logic [7:0] ch);
    int base;
    base = int'(digit_base);
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) return int'(ch) - int'(CH_UPPER_A);
    if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) return int'(ch) - int'(CH_LOWER_A);
    if (ch >= CH_ZERO && ch <= CH_NINE) return base + int'(ch) - int'(CH_ZERO);
    case (ch)
      CH_DOT:   return base + 10;
      CH_COLON: return base + 11;
      CH_BANG:  return base + 12;
      CH_QUERY: return base + 13;
      CH_PLUS:  return base + 14;
      CH_MINUS: return base + 15;
      CH_SLASH: return base + 16;
      CH_SPACE: return base + 17;
      default:  return -1;
    endcase
  endfunction

  task automatic push_status(input logic [1:0] st);
    pixel_write_t w;
    w = '{x: '0, y: '0, color: '0, wr: 1'b0, status: st, last: 1'b1};
    pending_writes.push_back(w);
  endtask

  task automatic predict_glyph(input text_item_t it);
    int           tile;
    int           n;
    logic [7:0]   px;
    pixel_write_t w;
    if (it.mode == MODE_LOAD) begin
      glyph_store[int'(it.tile_num) * TILE_PIX + int'(it.pix_ofs)] = it.pix_val;
      return;
    end
    if (it.first) begin
      cursor_col  = it.sx;
      string_dead = 1'b0;
    end else if (string_dead) begin
      push_status(ST_SKIPPED);
      return;
    end
    tile = glyph_index(it.ch);
    if (tile < 0) begin
      string_dead = 1'b1;
      push_status(ST_UNMAPPED);
      return;
    end
    if (tile >= int'(tile_limit) || tile >= NUM_TILES_DEF) begin
      string_dead = 1'b1;
      push_status(ST_BEYOND);
      return;
    end
    n = 0;
    for (int j = 0; j < TILE_SIZE_DEF; j++) begin
      for (int i = 0; i < TILE_SIZE_DEF; i++) begin
        px = glyph_store[tile * TILE_PIX + j * TILE_SIZE_DEF + i];
        if (px != 8'd0) begin
          w = '{x: cursor_col + 12'(i), y: it.sy + 12'(j), color: px,
                wr: 1'b1, status: ST_OK, last: 1'b0};
          pending_writes.push_back(w);
          n++;
        end
      end
    end
    cursor_col = cursor_col + 12'(TILE_SIZE_DEF);
    if (n == 0) begin
      push_status(ST_OK);
    end else begin
      // flag the final pixel of this character
      w.last = 1'b1;
      pending_writes[pending_writes.size() - 1] = w;
    end
  endtask

  task automatic send_glyph(input text_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, it.sy, it.sx, it.ch, it.pix_val, it.pix_ofs, it.tile_num};
    s_axis_tuser  <= {it.first, it.mode};
    s_axis_tlast  <= it.last_ch;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_glyph(it);
  endtask

  function automatic text_item_t load_item(input logic [5:0] tnum, input logic [5:0] pofs,
                                           input logic [7:0] pval);
    text_item_t it;
    it.mode     = MODE_LOAD;
    it.tile_num = tnum;
    it.pix_ofs  = pofs;
    it.pix_val  = pval;
    it.ch       = 8'($urandom);
    it.sx       = 12'($urandom);
    it.sy       = 12'($urandom);
    it.first    = 1'($urandom);
    it.last_ch  = 1'($urandom);
    return it;
  endfunction

  function automatic text_item_t draw_item(input logic [7:0] ch, input logic [11:0] sx,
                                           input logic [11:0] sy, input logic first,
                                           input logic last_ch);
    text_item_t it;
    it.mode     = MODE_DRAW;
    it.tile_num = 6'($urandom);
    it.pix_ofs  = 6'($urandom);
    it.pix_val  = 8'($urandom);
    it.ch       = ch;
    it.sx       = sx;
    it.sy       = sy;
    it.first    = first;
    it.last_ch  = last_ch;
    return it;
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 30) return CH_UPPER_A + 8'($urandom_range(25));
    if (r < 50) return CH_LOWER_A + 8'($urandom_range(25));
    if (r < 65) return CH_ZERO + 8'($urandom_range(9));
    if (r < 85) begin
      case ($urandom_range(7))
        0: return CH_DOT;
        1: return CH_COLON;
        2: return CH_BANG;
        3: return CH_QUERY;
        4: return CH_PLUS;
        5: return CH_MINUS;
        6: return CH_SLASH;
        default: return CH_SPACE;
      endcase
    end
    if (r < 93) return 8'($urandom);
    return 8'($urandom_range(128, 255));
  endfunction

  // Let every result come out and the sequencer settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_TILES_PER_ROW) digit_base = val;
    else if (idx == REG_TILE_COUNT) tile_limit = val;
    @(posedge clk_i);
  endtask

  task automatic set_registers(input logic [CFG_W-1:0] base, input logic [CFG_W-1:0] count);
    wait_drained();
    write_reg(REG_TILES_PER_ROW, base);
    write_reg(REG_TILE_COUNT, count);
  endtask

  // Write every pixel of every tile: tile 0 solid, tile 43 blank, the rest sparse
  task automatic test_store_fill();
    logic [7:0] pval;
    idle_pct  = 0;
    stall_pct = 0;
    for (int t = 0; t < NUM_TILES_DEF; t++) begin
      for (int o = 0; o < TILE_PIX; o++) begin
        if (t == 0) pval = (o == TILE_PIX - 1) ? 8'd255 : 8'($urandom_range(1, 255));
        else if (t == 43) pval = 8'd0;
        else if ($urandom_range(99) < 30) pval = 8'($urandom_range(1, 255));
        else pval = 8'd0;
        send_glyph(load_item(6'(t), 6'(o), pval));
      end
    end
  endtask

  // Reset register values; every character class, wrap-around, abort and skip
  task automatic test_character_map();
    send_glyph(draw_item(CH_UPPER_A, 12'd4092, 12'd4093, 1'b1, 1'b1));
    send_glyph(draw_item(CH_LOWER_Z, 12'd0, 12'd0, 1'b1, 1'b1));
    send_glyph(draw_item(CH_UPPER_Z, 12'd100, 12'd200, 1'b1, 1'b0));
    send_glyph(draw_item(CH_LOWER_A, 12'd0, 12'd0, 1'b0, 1'b1));
    send_glyph(draw_item(CH_ZERO, 12'd4095, 12'd4095, 1'b1, 1'b0));
    send_glyph(draw_item(CH_NINE, 12'd0, 12'd0, 1'b0, 1'b1));
    send_glyph(draw_item(CH_DOT, 12'd8, 12'd16, 1'b1, 1'b0));
    send_glyph(draw_item(CH_COLON, 12'd8, 12'd16, 1'b0, 1'b0));
    send_glyph(draw_item(CH_BANG, 12'd8, 12'd16, 1'b0, 1'b0));
    send_glyph(draw_item(CH_QUERY, 12'd8, 12'd16, 1'b0, 1'b0));
    send_glyph(draw_item(CH_PLUS, 12'd8, 12'd16, 1'b0, 1'b0));
    send_glyph(draw_item(CH_MINUS, 12'd8, 12'd16, 1'b0, 1'b0));
    send_glyph(draw_item(CH_SLASH, 12'd8, 12'd16, 1'b0, 1'b0));
    send_glyph(draw_item(CH_SPACE, 12'd8, 12'd16, 1'b0, 1'b1));
    // unmapped byte kills the rest of its string
    send_glyph(draw_item(8'hFF, 12'd300, 12'd40, 1'b1, 1'b0));
    send_glyph(draw_item(CH_UPPER_A + 8'd1, 12'd300, 12'd40, 1'b0, 1'b0));
    send_glyph(draw_item(CH_ZERO + 8'd1, 12'd300, 12'd40, 1'b0, 1'b1));
    send_glyph(draw_item(8'h00, 12'd500, 12'd50, 1'b1, 1'b1));
    send_glyph(draw_item(CH_UPPER_A + 8'd16, 12'd500, 12'd50, 1'b1, 1'b1));
    send_glyph(load_item(6'd5, 6'd63, 8'd255));
    send_glyph(load_item(6'd5, 6'd0, 8'd0));
    send_glyph(draw_item(CH_UPPER_A + 8'd5, 12'd2047, 12'd2048, 1'b1, 1'b1));
  endtask

  // Extremes of both registers, one single-character string per class
  task automatic test_register_limits();
    logic [CFG_W-1:0] bases  [7];
    logic [CFG_W-1:0] counts [7];
    bases  = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd26, 7'd46, 7'd26};
    counts = '{7'd64, 7'd64, 7'd64, 7'd127, 7'd0, 7'd64, 7'd26};
    for (int s = 0; s < 7; s++) begin
      set_registers(bases[s], counts[s]);
      send_glyph(draw_item(CH_UPPER_Z, 12'($urandom), 12'($urandom), 1'b1, 1'b1));
      send_glyph(draw_item(CH_ZERO, 12'($urandom), 12'($urandom), 1'b1, 1'b1));
      send_glyph(draw_item(CH_NINE, 12'($urandom), 12'($urandom), 1'b1, 1'b1));
      send_glyph(draw_item(CH_SPACE, 12'($urandom), 12'($urandom), 1'b1, 1'b1));
    end
  endtask

  task automatic random_phase(input int idle, input int stall, input int n_items);
    int         sent;
    int         r;
    int         len;
    logic [7:0] pval;
    if ($urandom_range(99) < 60) set_registers(TPR_RESET, TCOUNT_RESET);
    else set_registers(7'($urandom_range(1, 46)), 7'($urandom_range(20, 64)));
    idle_pct  = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 15) begin
        pval = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom);
        send_glyph(load_item(6'($urandom), 6'($urandom), pval));
        sent++;
      end else if (r < 25) begin
        // stray character: framing bits left to chance
        send_glyph(draw_item(pick_char(), 12'($urandom), 12'($urandom),
                             1'($urandom), 1'($urandom)));
        sent++;
      end else begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          send_glyph(draw_item(pick_char(), 12'($urandom), 12'($urandom),
                               k == 0, k == len - 1));
        end
        sent += len;
      end
    end
  endtask

  task automatic test_random_strings();
    random_phase(0, 0, 68);
    random_phase(54, 0, 68);
    random_phase(0, 54, 68);
    random_phase(8, 8, 68);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_store_fill();
    test_character_map();
    test_register_limits();
    test_random_strings();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
